// ===== src/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest palette colour package
// Shared colour types, field widths and operation codes of the palette core.
// ----------------------------------------------------------------------------
package npc_pkg;

   localparam int COLOUR_W = 8;
   localparam int SQ_W     = 16;
   localparam int DIST_W   = 18;
   localparam int SIZE_W   = 9;
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 8;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef logic [COLOUR_W-1:0] colour_type;

   typedef struct packed {
      colour_type red;
      colour_type green;
      colour_type blue;
   } rgb_type;

endpackage

// ===== src/npc_dist.sv =====
// ----------------------------------------------------------------------------
// Squared colour distance unit
// Registers the three channel squares, then sums them into an 18-bit distance.
// ----------------------------------------------------------------------------
module npc_dist
   import npc_pkg::*;
(
   input  logic              clock,
   input  rgb_type           entry,
   input  rgb_type           query,
   output logic [DIST_W-1:0] distance
);

   logic [SQ_W-1:0] sq_red_ff;
   logic [SQ_W-1:0] sq_green_ff;
   logic [SQ_W-1:0] sq_blue_ff;
   logic [SQ_W-1:0] sq_red_in;
   logic [SQ_W-1:0] sq_green_in;
   logic [SQ_W-1:0] sq_blue_in;

   function automatic logic [SQ_W-1:0] square_diff(colour_type a, colour_type b);
      colour_type d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   always_comb begin
      sq_red_in   = square_diff(entry.red,   query.red);
      sq_green_in = square_diff(entry.green, query.green);
      sq_blue_in  = square_diff(entry.blue,  query.blue);
   end

   always_ff @(posedge clock) begin
      sq_red_ff   <= sq_red_in;
      sq_green_ff <= sq_green_in;
      sq_blue_ff  <= sq_blue_in;
   end

   assign distance = DIST_W'(sq_red_ff) + DIST_W'(sq_green_ff) + DIST_W'(sq_blue_ff);

endmodule

// ===== src/nearest_palette_color_core.sv =====
// ----------------------------------------------------------------------------
// Nearest palette colour core
// Holds one RGB8 palette in a synchronous memory and answers nearest-colour
// queries and index read-backs against it.
// ----------------------------------------------------------------------------
// The req_ channel carries one operation per transaction: write an entry,
// query the nearest entry to a colour, or read an entry back. Every request
// transaction yields exactly one rsp_ transaction, in order. The csr_ channel
// writes the palette size and is always ready; the user must see that it is
// written only while the core is idle, which the core does not enforce.
// A write, a read-back or an unused operation passes from acceptance through
// ST_FINISH into the response register. A query scans the palette through
// the single memory read port, one entry a cycle, through the distance unit
// and the running best, then ST_FINISH; the scan sets the rate. A new
// request is taken in the cycle after the previous one has been placed in the
// response register, and a finished response may wait there while the next
// request is in progress.
// Reset clears the palette size and the control state; the palette memory is
// not cleared, and entries read before they are written return anything.
// While rsp_stall is high the response register holds, and a following item
// waits in its final cycle until the register is free.
// ----------------------------------------------------------------------------
module nearest_palette_color_core
   import npc_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  colour_type          req_red,
   input  colour_type          req_green,
   input  colour_type          req_blue,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [INDEX_W-1:0]  rsp_best_index,
   output logic [DIST_W-1:0]   rsp_best_distance,
   output colour_type          rsp_out_red,
   output colour_type          rsp_out_green,
   output colour_type          rsp_out_blue,
   output logic                rsp_in_range,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SIZE_W-1:0]   csr_palette_size
);

   localparam int IDX_W = $clog2(PALETTE_DEPTH);
   localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Configuration.
   logic [SIZE_W-1:0] palette_size_ff;
   logic [SIZE_W-1:0] size_eff;

   // Palette memory.
   rgb_type           palette_mem [PALETTE_DEPTH];
   rgb_type           rd_data_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;

   // Captured request.
   logic [OP_W-1:0]    op_ff;
   logic [INDEX_W-1:0] idx_ff;
   rgb_type            query_ff;
   logic               req_accept;

   // Scan pipeline.
   logic [CNT_W-1:0]  scan_cnt_ff;
   logic [CNT_W-1:0]  scan_cnt_in;
   logic              scan_issue;
   logic              scan_done;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              sq_vld_ff;
   logic [IDX_W-1:0]  sq_idx_ff;
   logic [DIST_W-1:0] entry_distance;
   logic              take_best;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [IDX_W-1:0]  best_idx_in;
   logic [DIST_W-1:0] best_dist_ff;
   logic [DIST_W-1:0] best_dist_in;

   // Control and response registers.
   state_type          state_ff;
   state_type          state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [INDEX_W-1:0] rsp_best_index_ff;
   logic [INDEX_W-1:0] rsp_best_index_in;
   logic [DIST_W-1:0]  rsp_best_distance_ff;
   logic [DIST_W-1:0]  rsp_best_distance_in;
   rgb_type            rsp_colour_ff;
   rgb_type            rsp_colour_in;
   logic               rsp_in_range_ff;
   logic               rsp_in_range_in;
   logic               in_range;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         palette_size_ff <= csr_palette_size;
      end
   end

   assign size_eff = (palette_size_ff > SIZE_W'(PALETTE_DEPTH)) ?
                     SIZE_W'(PALETTE_DEPTH) : palette_size_ff;

   // Writes land at acceptance; reads only occur in the scan or at a read-back
   // acceptance, so a write and a read never meet in the same cycle.
   assign wr_en = req_accept && (req_op == OP_WRITE) &&
                  ({1'b0, req_entry_index} < SIZE_W'(PALETTE_DEPTH));

   assign scan_issue = (state_ff == ST_SCAN) && (SIZE_W'(scan_cnt_ff) < size_eff);
   assign rd_en      = scan_issue || (req_accept && (req_op == OP_READ));
   assign rd_addr    = (state_ff == ST_SCAN) ? scan_cnt_ff[IDX_W-1:0]
                                             : req_entry_index[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[req_entry_index[IDX_W-1:0]] <= {req_red, req_green, req_blue};
      end
      if (rd_en) begin
         rd_data_ff <= palette_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_op;
         idx_ff   <= req_entry_index;
         query_ff <= {req_red, req_green, req_blue};
      end
   end

   npc_dist u_dist (
      .clock    (clock),
      .entry    (rd_data_ff),
      .query    (query_ff),
      .distance (entry_distance)
   );

   // The first entry is always taken, later ones only when strictly closer,
   // so the lowest index wins a tie.
   assign take_best = sq_vld_ff && ((sq_idx_ff == '0) || (entry_distance < best_dist_ff));
   assign scan_done = (state_ff == ST_SCAN) && !scan_issue && !rd_vld_ff && !sq_vld_ff;

   always_comb begin
      scan_cnt_in  = scan_cnt_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      if (req_accept) begin
         scan_cnt_in  = '0;
         best_idx_in  = '0;
         best_dist_in = '0;
      end else begin
         if (scan_issue) begin
            scan_cnt_in = scan_cnt_ff + CNT_W'(1);
         end
         if (take_best) begin
            best_idx_in  = sq_idx_ff;
            best_dist_in = entry_distance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= scan_issue;
         sq_vld_ff <= rd_vld_ff;
      end
      scan_cnt_ff  <= scan_cnt_in;
      rd_idx_ff    <= scan_cnt_ff[IDX_W-1:0];
      sq_idx_ff    <= rd_idx_ff;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
   end

   assign in_range = ({1'b0, idx_ff} < size_eff);

   always_comb begin
      state_in             = state_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_best_index_in    = rsp_best_index_ff;
      rsp_best_distance_in = rsp_best_distance_ff;
      rsp_colour_in        = rsp_colour_ff;
      rsp_in_range_in      = rsp_in_range_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_op == OP_QUERY) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in             = ST_IDLE;
               rsp_valid_in         = 1'b1;
               rsp_best_index_in    = '0;
               rsp_best_distance_in = '0;
               rsp_colour_in        = '0;
               rsp_in_range_in      = 1'b0;
               if (op_ff == OP_QUERY) begin
                  rsp_best_index_in    = INDEX_W'(best_idx_ff);
                  rsp_best_distance_in = best_dist_ff;
               end else if ((op_ff == OP_READ) && in_range) begin
                  rsp_colour_in   = rd_data_ff;
                  rsp_in_range_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         rsp_valid_ff         <= 1'b0;
         rsp_best_index_ff    <= '0;
         rsp_best_distance_ff <= '0;
         rsp_colour_ff        <= '0;
         rsp_in_range_ff      <= 1'b0;
      end else begin
         state_ff             <= state_in;
         rsp_valid_ff         <= rsp_valid_in;
         rsp_best_index_ff    <= rsp_best_index_in;
         rsp_best_distance_ff <= rsp_best_distance_in;
         rsp_colour_ff        <= rsp_colour_in;
         rsp_in_range_ff      <= rsp_in_range_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_best_index_ff;
   assign rsp_best_distance = rsp_best_distance_ff;
   assign rsp_out_red       = rsp_colour_ff.red;
   assign rsp_out_green     = rsp_colour_ff.green;
   assign rsp_out_blue      = rsp_colour_ff.blue;
   assign rsp_in_range      = rsp_in_range_ff;

   // The distance pipeline is only ever busy during a scan.
   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff || sq_vld_ff) |-> (state_ff == ST_SCAN))
      else $error("scan pipeline busy outside a scan");

   // A scan never reads beyond the effective palette size.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ({1'b0, rd_idx_ff} < size_eff))
      else $error("scan read beyond palette size");

   // The running best never exceeds the distance just compared.
   a_best_min: assert property (@(posedge clock) disable iff (reset)
      (sq_vld_ff && !req_accept) |=> (best_dist_ff <= $past(entry_distance)))
      else $error("running best distance above compared distance");

   // A finished item with a free response register is delivered at once.
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && !rsp_valid_ff) |=>
      (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished item not loaded into response register");

endmodule

// ===== tb/sv/tb_nearest_palette_color_core.sv =====
// ----------------------------------------------------------------------------
// Nearest palette colour core testbench
// Drives palette writes, nearest-colour queries and read-backs into the core
// and scores every response against a cycle-free prediction of the palette. A
// short table of hand-picked transactions comes first. Random traffic follows
// over a run of palette sizes, under changing sender gaps and response back-pressure.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_core;
   import npc_pkg::*;

   localparam int DEPTH           = 256;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 270;
   localparam int CYCLE_LIMIT     = 2000000;

   // Opcode left unused by the core; it must change nothing.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] index;
      rgb_type            colour;
   } palette_request_type;

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic [DIST_W-1:0]  best_distance;
      rgb_type            colour;
      logic               in_range;
   } palette_response_type;

   typedef struct packed {
      logic                 resize;
      logic [SIZE_W-1:0]    size;
      palette_request_type  request;
      logic                 known;
      palette_response_type answer;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [OP_W-1:0]    req_op;
   logic [INDEX_W-1:0] req_entry_index;
   colour_type         req_red;
   colour_type         req_green;
   colour_type         req_blue;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [INDEX_W-1:0] rsp_best_index;
   logic [DIST_W-1:0]  rsp_best_distance;
   colour_type         rsp_out_red;
   colour_type         rsp_out_green;
   colour_type         rsp_out_blue;
   logic               rsp_in_range;
   logic               csr_valid;
   logic               csr_ready;
   logic [SIZE_W-1:0]  csr_palette_size;

   rgb_type              palette_copy [DEPTH];
   bit                   written_entries [DEPTH];
   logic [SIZE_W-1:0]    size_copy = '0;
   palette_response_type expected_responses [$];
   directed_row_type     directed_rows [$];

   int unsigned sender_idle_pct   = 17;
   int unsigned receiver_idle_pct = 84;
   bit          hold_off_start    = 1'b0;
   int          mismatch_count    = 0;
   int          cycle_count       = 0;

   nearest_palette_color_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_in_range      (rsp_in_range),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_palette_size  (csr_palette_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned effective_size();
      return (size_copy > DEPTH) ? DEPTH : int'(size_copy);
   endfunction

   function automatic int unsigned channel_distance(input colour_type a, input colour_type b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   // Applies one transaction to the palette copy and returns the response it
   // should produce.
   function automatic palette_response_type predict_palette_response(
      input palette_request_type req);
      palette_response_type rsp;
      int unsigned          limit;
      int unsigned          distance;
      rsp   = '0;
      limit = effective_size();
      case (req.op)
         OP_WRITE: begin
            palette_copy[req.index]    = req.colour;
            written_entries[req.index] = 1'b1;
         end
         OP_QUERY: begin
            for (int i = 0; i < limit; i++) begin
               distance = channel_distance(palette_copy[i].red, req.colour.red)
                        + channel_distance(palette_copy[i].green, req.colour.green)
                        + channel_distance(palette_copy[i].blue, req.colour.blue);
               // Strictly less, so the lowest index keeps a tie.
               if (i == 0 || distance < rsp.best_distance) begin
                  rsp.best_distance = distance[DIST_W-1:0];
                  rsp.best_index    = i[INDEX_W-1:0];
               end
            end
         end
         OP_READ: begin
            if (req.index < limit) begin
               rsp.colour   = palette_copy[req.index];
               rsp.in_range = 1'b1;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic rgb_type pick_colour(input int unsigned limit);
      rgb_type c;
      int      v;
      c = rgb_type'($urandom);
      case ($urandom_range(9))
         5: begin
            for (int k = 0; k < 3; k++)
               c[8*k +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
         end
         6: begin
            if (limit != 0)
               c = palette_copy[$urandom_range(limit - 1)];
         end
         7, 8, 9: begin
            // Land close to a stored entry so that near-ties are common.
            if (limit != 0) begin
               c = palette_copy[$urandom_range(limit - 1)];
               for (int k = 0; k < 3; k++) begin
                  v = int'(c[8*k +: 8]) + int'($urandom_range(6)) - 3;
                  v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                  c[8*k +: 8] = v[7:0];
               end
            end
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic palette_request_type random_request();
      palette_request_type req;
      int unsigned         limit;
      int unsigned         roll;
      limit  = effective_size();
      roll   = $urandom_range(99);
      req.op = (roll < 35) ? OP_WRITE : (roll < 75) ? OP_QUERY : (roll < 95) ? OP_READ
                                                                             : OP_UNUSED;
      req.index = (limit != 0 && $urandom_range(1) == 1) ? INDEX_W'($urandom_range(limit - 1))
                                                         : INDEX_W'($urandom_range(255));
      req.colour = pick_colour(limit);
      return req;
   endfunction

   function automatic directed_row_type known_row(input logic [OP_W-1:0] op,
                                                  input logic [INDEX_W-1:0] index,
                                                  input rgb_type colour,
                                                  input palette_response_type answer);
      directed_row_type row;
      row         = '0;
      row.request = {op, index, colour};
      row.known   = 1'b1;
      row.answer  = answer;
      return row;
   endfunction

   function automatic directed_row_type resize_row(input logic [SIZE_W-1:0] size);
      directed_row_type row;
      row        = '0;
      row.resize = 1'b1;
      row.size   = size;
      return row;
   endfunction

   function automatic palette_response_type response_of(input logic [INDEX_W-1:0] best_index,
                                                        input logic [DIST_W-1:0] best_distance,
                                                        input rgb_type colour,
                                                        input logic in_range);
      return {best_index, best_distance, colour, in_range};
   endfunction

   // The valid from the previous transaction is left high; this task may lower
   // it for idle cycles, then places the new payload at a falling edge.
   task automatic send_request(input palette_request_type req, input bit known,
                               input palette_response_type answer);
      palette_response_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= req.op;
      req_entry_index <= req.index;
      req_red         <= req.colour.red;
      req_green       <= req.colour.green;
      req_blue        <= req.colour.blue;
      do @(posedge clock); while (req_stall);
      predicted = predict_palette_response(req);
      expected_responses.push_back(known ? answer : predicted);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_responses();
      while (expected_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_palette_size(input logic [SIZE_W-1:0] size);
      release_request();
      drain_responses();
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_palette_size <= size;
      do @(posedge clock); while (!csr_ready);
      size_copy = size;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Every entry that a query or read-back may touch must hold a known colour.
   task automatic fill_below(input int unsigned size);
      palette_request_type req;
      for (int i = 0; i < ((size > DEPTH) ? DEPTH : size); i++) begin
         if (!written_entries[i]) begin
            req.op     = OP_WRITE;
            req.index  = i[INDEX_W-1:0];
            req.colour = rgb_type'($urandom);
            send_request(req, 1'b0, '0);
         end
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            hold_left      = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      palette_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_best_index !== want.best_index) begin
               $error("best_index: expected %0d, got %0d", want.best_index, rsp_best_index);
               mismatch_count++;
            end
            if (rsp_best_distance !== want.best_distance) begin
               $error("best_distance: expected %0d, got %0d",
                      want.best_distance, rsp_best_distance);
               mismatch_count++;
            end
            if (rsp_out_red !== want.colour.red) begin
               $error("out_red: expected %0d, got %0d", want.colour.red, rsp_out_red);
               mismatch_count++;
            end
            if (rsp_out_green !== want.colour.green) begin
               $error("out_green: expected %0d, got %0d", want.colour.green, rsp_out_green);
               mismatch_count++;
            end
            if (rsp_out_blue !== want.colour.blue) begin
               $error("out_blue: expected %0d, got %0d", want.colour.blue, rsp_out_blue);
               mismatch_count++;
            end
            if (rsp_in_range !== want.in_range) begin
               $error("in_range: expected %0d, got %0d", want.in_range, rsp_in_range);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("nearest_palette_color_core regression: fail");
         $finish;
      end
   end

   initial begin
      palette_request_type req;
      logic [SIZE_W-1:0]   size;
      int                  count;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_WRITE;
      req_entry_index  = '0;
      req_red          = '0;
      req_green        = '0;
      req_blue         = '0;
      csr_valid        = 1'b0;
      csr_palette_size = '0;

      // Empty palette, unused opcode and read-backs beyond the size.
      directed_rows.push_back(known_row(OP_QUERY, 8'd0, 24'h804020, '0));
      directed_rows.push_back(known_row(OP_READ, 8'd0, 24'h000000, '0));
      directed_rows.push_back(known_row(OP_READ, 8'd255, 24'hffffff, '0));
      directed_rows.push_back(known_row(OP_UNUSED, 8'ha5, 24'h5a5a5a, '0));
      directed_rows.push_back(known_row(OP_WRITE, 8'd0, 24'h000000, '0));
      directed_rows.push_back(known_row(OP_WRITE, 8'd1, 24'hffffff, '0));
      directed_rows.push_back(known_row(OP_WRITE, 8'd2, 24'hff0000, '0));
      directed_rows.push_back(known_row(OP_WRITE, 8'd3, 24'h00ff00, '0));
      directed_rows.push_back(known_row(OP_WRITE, 8'd4, 24'h0000ff, '0));
      directed_rows.push_back(known_row(OP_WRITE, 8'd5, 24'hff0000, '0));
      directed_rows.push_back(known_row(OP_WRITE, 8'd255, 24'h123456, '0));
      directed_rows.push_back(resize_row(9'd6));
      directed_rows.push_back(known_row(OP_QUERY, 8'd0, 24'h000000,
                                        response_of(8'd0, 18'd0, 24'h0, 1'b0)));
      directed_rows.push_back(known_row(OP_QUERY, 8'd0, 24'hffffff,
                                        response_of(8'd1, 18'd0, 24'h0, 1'b0)));
      directed_rows.push_back(known_row(OP_QUERY, 8'd0, 24'h808080, '0));
      directed_rows[$].known = 1'b0;
      // Yellow sits equally far from white, red and green.
      directed_rows.push_back(known_row(OP_QUERY, 8'hff, 24'hffff00, '0));
      directed_rows[$].known = 1'b0;
      directed_rows.push_back(known_row(OP_QUERY, 8'd0, 24'hf00000,
                                        response_of(8'd2, 18'd225, 24'h0, 1'b0)));
      directed_rows.push_back(known_row(OP_READ, 8'd4, 24'hffffff,
                                        response_of(8'd0, 18'd0, 24'h0000ff, 1'b1)));
      directed_rows.push_back(known_row(OP_READ, 8'd6, 24'h000000, '0));
      directed_rows.push_back(known_row(OP_READ, 8'd255, 24'h000000, '0));
      directed_rows.push_back(resize_row(9'd0));
      directed_rows.push_back(known_row(OP_QUERY, 8'd0, 24'h102030, '0));
      directed_rows.push_back(known_row(OP_READ, 8'd0, 24'h000000, '0));
      directed_rows.push_back(resize_row(9'd1));
      directed_rows.push_back(known_row(OP_QUERY, 8'd0, 24'hffffff,
                                        response_of(8'd0, 18'd195075, 24'h0, 1'b0)));
      directed_rows.push_back(known_row(OP_READ, 8'd0, 24'h000000,
                                        response_of(8'd0, 18'd0, 24'h000000, 1'b1)));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].resize)
            write_palette_size(directed_rows[i].size);
         else
            send_request(directed_rows[i].request, directed_rows[i].known,
                         directed_rows[i].answer);
      end

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin size = 9'd8;   count = 110; end
            1: begin size = 9'd1;   count = 60;  end
            2: begin size = 9'd2;   count = 60;  end
            3: begin size = 9'd0;   count = 30;  end
            4: begin size = 9'd256; count = 50;  end
            5: begin size = 9'd511; count = 30;  end
            6: begin size = SIZE_W'(3 + $urandom_range(252)); count = 100; end
            7: begin size = SIZE_W'($urandom_range(511));     count = 120; end
            default: begin size = 9'd4; count = 100; end
         endcase
         if (phase == 4) begin
            sender_idle_pct   = 84;
            receiver_idle_pct = 17;
         end else if (phase == 7) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         fill_below(size);
         write_palette_size(size);
         for (int n = 0; n < count; n++) begin
            // With a tiny palette the core fills quickly behind a long hold-off.
            if (phase == 8 && n == 10)
               hold_off_start = 1'b1;
            if (phase == 8 && n == 60) begin
               release_request();
               drain_responses();
            end
            req = random_request();
            send_request(req, 1'b0, '0);
         end
      end

      release_request();
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("nearest_palette_color_core regression: pass");
      else
         $display("nearest_palette_color_core regression: fail");
      $finish;
   end

endmodule
